[rtl/bws_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Bayesian wavelet shrinkage pipeline.
// No dependencies; imported by bayesian_wavelet_shrink, bws_exp and the testbench.
package bws_pkg;

    // Width of the coefficient, register and result words.
    localparam int COEF_W = 32;

    // Exponent argument q in Q16.16 below 16.0, so it fits in 20 bits.
    localparam int Q_BITS = 20;

    // Exponential results in Q0.16, 0 to 1.0 inclusive.
    localparam int E_W = 17;
    localparam logic [E_W-1:0] E_ONE = 17'h1_0000;

    // Sum of two exponentials.
    localparam int DEN_W = E_W + 1;

    // Quotient width of the gain divisions (Q0.31 values up to 1.0).
    localparam int GAIN_BITS = 32;

    // Register stages inside the exponential unit.
    localparam int EXP_LAT = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEAN_OFFSET  = 2'd0,
        CFG_SIGNAL_POWER = 2'd1,
        CFG_NOISE_POWER  = 2'd2
    } cfg_idx_t;

    // Special-case controls for one exponential evaluation.
    typedef struct packed {
        logic ovf;       // argument at or above 16.0
        logic var_zero;  // variance is zero
        logic d2_zero;   // squared deviation is zero
    } exp_ctl_t;

endpackage

[rtl/bayesian_wavelet_shrink.sv]
`timescale 1ns / 1ps
// Bayesian Wiener shrinkage of wavelet coefficients, top level.
// Accepts one item per cycle while the skid entry is empty.
// Depth is set by the two bit-serial divider pipelines (20 and 32 stages).
// A skid entry behind the output register catches the item pushed as a stall
// begins; the whole pipeline and in_ready then hold until it drains.
// Reset (rst_n low, async) clears all valid bits and the three registers to 0.
module bayesian_wavelet_shrink
    import bws_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 8
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [COEF_W-1:0] coef_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [COEF_W-1:0] coef_out,
    output logic                     passed_through
);

    typedef struct packed {
        logic [COEF_W-1:0] y;
        logic              ovf1;
        logic              ovf2;
        logic              d2z;
    } qside_t;

    typedef struct packed {
        logic [COEF_W-1:0] y;
        logic              den0;
    } wside_t;

    // Configuration registers.
    logic [COEF_W-1:0] mean_reg;
    logic [COEF_W-1:0] sig_reg;
    logic [COEF_W-1:0] noise_reg;
    logic [COEF_W:0]   sn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg  <= '0;
            sig_reg   <= '0;
            noise_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MEAN_OFFSET:  mean_reg  <= cfg_data;
                CFG_SIGNAL_POWER: sig_reg   <= cfg_data;
                CFG_NOISE_POWER:  noise_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign sn = {1'b0, sig_reg} + {1'b0, noise_reg};

    // The whole pipeline advances together unless the skid entry is full.
    logic pipe_en;
    logic skid_valid_reg;

    assign pipe_en  = !skid_valid_reg;
    assign in_ready = pipe_en;

    // Front stages: capture, deviation, square, range check.
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [COEF_W-1:0] s1_y_reg, s2_y_reg, s3_y_reg, s4_y_reg;
    logic [COEF_W-1:0] s2_ad_reg;
    logic [63:0]       s3_d2_reg, s4_d2_reg;
    logic              s4_ovf1_reg, s4_ovf2_reg, s4_d2z_reg;
    logic [COEF_W:0]   diff;
    logic [COEF_W:0]   ad_wide;

    assign diff    = {s1_y_reg[COEF_W-1], s1_y_reg} - {mean_reg[COEF_W-1], mean_reg};
    assign ad_wide = diff[COEF_W] ? ({(COEF_W+1){1'b0}} - diff) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_y_reg    <= coef_in;
            s2_y_reg    <= s1_y_reg;
            s2_ad_reg   <= ad_wide[COEF_W-1:0];
            s3_y_reg    <= s2_y_reg;
            s3_d2_reg   <= s2_ad_reg * s2_ad_reg;
            s4_y_reg    <= s3_y_reg;
            s4_d2_reg   <= s3_d2_reg;
            // The argument reaches 16.0 when d2 >= 2V * 2^20.
            s4_ovf1_reg <= (s3_d2_reg >= {11'd0, noise_reg, 21'd0});
            s4_ovf2_reg <= (s3_d2_reg >= {10'd0, sn, 21'd0});
            s4_d2z_reg  <= (s3_d2_reg == '0);
        end
    end

    // Exponent arguments q = d2 / (2V) for both variances.
    logic [Q_BITS-1:0] q1, q2;

    bws_div #(
        .NUM_W (64),
        .DEN_W (COEF_W + 2),
        .Q_W   (Q_BITS)
    ) u_div_q1 (
        .clk (clk),
        .en  (pipe_en),
        .num (s4_d2_reg),
        .den ({1'b0, noise_reg, 1'b0}),
        .quo (q1)
    );

    bws_div #(
        .NUM_W (64),
        .DEN_W (COEF_W + 2),
        .Q_W   (Q_BITS)
    ) u_div_q2 (
        .clk (clk),
        .en  (pipe_en),
        .num (s4_d2_reg),
        .den ({sn, 1'b0}),
        .quo (q2)
    );

    logic [Q_BITS-1:0] qd_valid_reg;
    qside_t            qd_side_reg [Q_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qd_valid_reg <= '0;
        else if (pipe_en)
            qd_valid_reg <= {qd_valid_reg[Q_BITS-2:0], s4_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            qd_side_reg[0] <= '{y: s4_y_reg, ovf1: s4_ovf1_reg, ovf2: s4_ovf2_reg,
                                d2z: s4_d2z_reg};
            for (int i = 1; i < Q_BITS; i++)
                qd_side_reg[i] <= qd_side_reg[i-1];
        end
    end

    // Exponentials e1 = exp(-q1), e2 = exp(-q2).
    exp_ctl_t       ctl1, ctl2;
    logic [E_W-1:0] e1, e2;

    assign ctl1 = '{ovf: qd_side_reg[Q_BITS-1].ovf1, var_zero: (noise_reg == '0),
                    d2_zero: qd_side_reg[Q_BITS-1].d2z};
    assign ctl2 = '{ovf: qd_side_reg[Q_BITS-1].ovf2, var_zero: (sn == '0),
                    d2_zero: qd_side_reg[Q_BITS-1].d2z};

    bws_exp #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_exp1 (
        .clk (clk),
        .en  (pipe_en),
        .q   (q1),
        .ctl (ctl1),
        .e   (e1)
    );

    bws_exp #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_exp2 (
        .clk (clk),
        .en  (pipe_en),
        .q   (q2),
        .ctl (ctl2),
        .e   (e2)
    );

    logic [EXP_LAT-1:0] xd_valid_reg;
    logic [COEF_W-1:0]  xd_y_reg [EXP_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xd_valid_reg <= '0;
        else if (pipe_en)
            xd_valid_reg <= {xd_valid_reg[EXP_LAT-2:0], qd_valid_reg[Q_BITS-1]};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            xd_y_reg[0] <= qd_side_reg[Q_BITS-1].y;
            for (int i = 1; i < EXP_LAT; i++)
                xd_y_reg[i] <= xd_y_reg[i-1];
        end
    end

    // Denominator e1 + e2.
    logic              s5_valid_reg;
    logic [COEF_W-1:0] s5_y_reg;
    logic [E_W-1:0]    s5_e2_reg;
    logic [DEN_W-1:0]  s5_den_reg;
    logic              s5_den0_reg;
    logic [DEN_W-1:0]  den_sum;

    assign den_sum = {1'b0, e1} + {1'b0, e2};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (pipe_en)
            s5_valid_reg <= xd_valid_reg[EXP_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s5_y_reg    <= xd_y_reg[EXP_LAT-1];
            s5_e2_reg   <= e2;
            s5_den_reg  <= den_sum;
            s5_den0_reg <= (den_sum == '0);
        end
    end

    // Gains w = e2 / (e1 + e2) and s = S / (S + N), both in Q0.31.
    logic [GAIN_BITS-1:0] w_q, s_q;

    bws_div #(
        .NUM_W (E_W + 31),
        .DEN_W (DEN_W),
        .Q_W   (GAIN_BITS)
    ) u_div_w (
        .clk (clk),
        .en  (pipe_en),
        .num ({s5_e2_reg, 31'd0}),
        .den (s5_den_reg),
        .quo (w_q)
    );

    bws_div #(
        .NUM_W (COEF_W + 31),
        .DEN_W (COEF_W + 1),
        .Q_W   (GAIN_BITS)
    ) u_div_s (
        .clk (clk),
        .en  (pipe_en),
        .num ({sig_reg, 31'd0}),
        .den (sn),
        .quo (s_q)
    );

    logic [GAIN_BITS-1:0] wd_valid_reg;
    wside_t               wd_side_reg [GAIN_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wd_valid_reg <= '0;
        else if (pipe_en)
            wd_valid_reg <= {wd_valid_reg[GAIN_BITS-2:0], s5_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            wd_side_reg[0] <= '{y: s5_y_reg, den0: s5_den0_reg};
            for (int i = 1; i < GAIN_BITS; i++)
                wd_side_reg[i] <= wd_side_reg[i-1];
        end
    end

    // Combined gain m = s * w, then |y| * m.
    logic              s6_valid_reg, s7_valid_reg;
    logic [COEF_W-1:0] s6_y_reg, s7_y_reg;
    logic              s6_den0_reg, s7_den0_reg;
    logic [COEF_W-1:0] s6_m_reg;
    logic [COEF_W-1:0] s6_ay_reg;
    logic [63:0]       gain_prod;
    logic [63:0]       s7_prod_reg;
    logic [COEF_W-1:0] y6_in;

    assign gain_prod = s_q * w_q;
    assign y6_in     = wd_side_reg[GAIN_BITS-1].y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s6_valid_reg <= wd_valid_reg[GAIN_BITS-1];
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s6_y_reg    <= y6_in;
            s6_den0_reg <= wd_side_reg[GAIN_BITS-1].den0;
            s6_m_reg    <= gain_prod[62:31];
            s6_ay_reg   <= y6_in[COEF_W-1] ? (COEF_W'(0) - y6_in) : y6_in;
            s7_y_reg    <= s6_y_reg;
            s7_den0_reg <= s6_den0_reg;
            s7_prod_reg <= s6_ay_reg * s6_m_reg;
        end
    end

    // Round, restore the sign, saturate and pick the special cases.
    logic [63:0]              rnd;
    logic [COEF_W:0]          mag;
    logic signed [COEF_W+1:0] res_wide;
    logic [COEF_W-1:0]        res_sat;
    logic [COEF_W-1:0]        res_coef;
    logic                     res_pass;

    assign rnd      = s7_prod_reg + 64'h0000_0000_4000_0000;
    assign mag      = rnd[63:31];
    assign res_wide = s7_y_reg[COEF_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_comb
    begin
        if (res_wide > 34'sd2147483647)
            res_sat = 32'h7FFF_FFFF;
        else if (res_wide < -34'sd2147483648)
            res_sat = 32'h8000_0000;
        else
            res_sat = res_wide[COEF_W-1:0];

        if (sig_reg == '0 && noise_reg == '0)
        begin
            res_coef = '0;
            res_pass = 1'b0;
        end
        else if (s7_den0_reg)
        begin
            res_coef = s7_y_reg;
            res_pass = 1'b1;
        end
        else
        begin
            res_coef = res_sat;
            res_pass = 1'b0;
        end
    end

    // Output register with one skid entry behind it.
    logic              out_valid_reg;
    logic [COEF_W-1:0] out_coef_reg, skid_coef_reg;
    logic              out_pass_reg, skid_pass_reg;
    logic              push;

    assign push = pipe_en && s7_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_coef_reg <= skid_coef_reg;
                out_pass_reg <= skid_pass_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_coef_reg <= res_coef;
                out_pass_reg <= res_pass;
            end
            else
            begin
                skid_coef_reg <= res_coef;
                skid_pass_reg <= res_pass;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign coef_out       = out_coef_reg;
    assign passed_through = out_pass_reg;

endmodule

[rtl/bws_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; the quotient must be known to fit in Q_W bits.
module bws_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 34,
    parameter int Q_W   = 20
)(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [CW-1:0]    rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        logic [CW-1:0]    rem_in;
        logic [CW-1:0]    sub;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in;
        logic [Q_W-1:0]   quo_next;
        logic             take;

        if (j == 0) begin : g_first
            assign rem_in = CW'(num);
            assign den_in = den;
            assign quo_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        // Trial subtraction of the shifted divisor for this quotient bit.
        assign sub  = CW'(den_in) << (Q_W - 1 - j);
        assign take = (rem_in >= sub);

        always_comb
        begin
            quo_next = quo_in;
            quo_next[Q_W-1-j] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= take ? rem_in - sub : rem_in;
                den_reg[j] <= den_in;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

[rtl/bws_exp.sv]
`timescale 1ns / 1ps
// Three-stage exp(-q) unit: table lookup, interpolation product, rounding.
// Depends on bws_pkg for widths and the special-case control struct.
module bws_exp
    import bws_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 8
)(
    input  logic              clk,
    input  logic              en,
    input  logic [Q_BITS-1:0] q,
    input  exp_ctl_t          ctl,
    output logic [E_W-1:0]    e
);

    localparam int TBL_N = 1 << EXP_TABLE_BITS;
    localparam int F     = Q_BITS - EXP_TABLE_BITS;

    typedef logic [31:0] tbl_t [TBL_N+1];

    // Samples of exp(-k*h) in Q0.31, h = 16/TBL_N, built by repeated
    // multiplication with a Taylor-series value of exp(-h).
    function automatic tbl_t build_tbl();
        tbl_t        t;
        logic [63:0] h;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        h    = 64'd1 << (35 - EXP_TABLE_BITS);
        term = 64'd1 << 31;
        pos  = 64'd1 << 31;
        neg  = '0;
        for (int n = 1; n <= 30; n++)
        begin
            term = ((term * h) >> 31) / 64'(n);
            if ((n & 1) != 0)
                neg = neg + term;
            else
                pos = pos + term;
        end
        r = pos - neg;
        t[0] = 32'h8000_0000;
        for (int k = 1; k <= TBL_N; k++)
            t[k] = 32'((64'(t[k-1]) * r + (64'd1 << 30)) >> 31);
        return t;
    endfunction

    localparam tbl_t EXP_TBL = build_tbl();

    logic [EXP_TABLE_BITS:0] idx_a;
    logic [EXP_TABLE_BITS:0] idx_b;

    logic [31:0]   a1_reg;
    logic [31:0]   b1_reg;
    logic [F-1:0]  f1_reg;
    logic          force1_reg;
    logic          one1_reg;

    logic [31:0]   a2_reg;
    logic [31+F:0] prod2_reg;
    logic          force2_reg;
    logic          one2_reg;

    logic [31:0]   v;
    logic [31:0]   v_rnd;
    logic [E_W-1:0] e_next;
    logic [E_W-1:0] e_reg;

    // Stage 1: look up the two neighboring samples.
    assign idx_a = {1'b0, q[Q_BITS-1:F]};
    assign idx_b = idx_a + 1'b1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg     <= EXP_TBL[idx_a];
            b1_reg     <= EXP_TBL[idx_b];
            f1_reg     <= q[F-1:0];
            force1_reg <= ctl.var_zero | ctl.ovf;
            one1_reg   <= ctl.var_zero & ctl.d2_zero;
        end
    end

    // Stage 2: slope times the fractional position.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg     <= a1_reg;
            prod2_reg  <= (a1_reg - b1_reg) * f1_reg;
            force2_reg <= force1_reg;
            one2_reg   <= one1_reg;
        end
    end

    // Stage 3: interpolate, round to Q0.16 and apply the special cases.
    assign v     = a2_reg - 32'(prod2_reg >> F);
    assign v_rnd = v + 32'h0000_4000;

    always_comb
    begin
        if (force2_reg)
            e_next = one2_reg ? E_ONE : '0;
        else
            e_next = v_rnd[31:15];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            e_reg <= e_next;
    end

    assign e = e_reg;

endmodule

[verif/bayesian_wavelet_shrink_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bayesian_wavelet_shrink: random and directed
// coefficients under several register settings, with a built-in gain predictor.
// Depends on rtl/bws_pkg.sv and rtl/bayesian_wavelet_shrink.sv with its submodules.
module bayesian_wavelet_shrink_tb;
    import bws_pkg::*;

    localparam int TBL_BITS = 8;
    localparam int TBL_N = 1 << TBL_BITS;
    localparam int FRAC = 20 - TBL_BITS;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [COEF_W-1:0] coef;
        logic                     thru;
    } shrink_res_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [COEF_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [COEF_W-1:0] coef_in;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [COEF_W-1:0] coef_out;
    logic                     passed_through;

    // Predictor copy of the registers and the exponential table.
    longint                   mu_q;
    longint unsigned          sig_q;
    longint unsigned          noi_q;
    longint unsigned          exp_tbl [0:TBL_N];

    logic signed [COEF_W-1:0] coef_pending [$];
    shrink_res_t              shrink_expected [$];
    int                       snd_idle;
    int                       rcv_idle;
    bit                       hold_off;
    int                       mismatches;
    int                       cycles;
    int                       items_queued;

    bayesian_wavelet_shrink uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .coef_in        (coef_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .coef_out       (coef_out),
        .passed_through (passed_through)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Table of exp(-k*h) in Q0.31 from a Taylor series for exp(-h).
    function automatic void build_exp_table();
        longint unsigned h;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned r;
        h = 64'd1 << (35 - TBL_BITS);
        term = 64'd1 << 31;
        pos = 64'd1 << 31;
        neg = 0;
        for (int n = 1; n <= 30; n++)
        begin
            term = ((term * h) >> 31) / n;
            if (n % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        r = pos - neg;
        exp_tbl[0] = 64'd1 << 31;
        for (int k = 1; k <= TBL_N; k++)
            exp_tbl[k] = (exp_tbl[k-1] * r + (64'd1 << 30)) >> 31;
    endfunction

    // exp(-sq/(2*variance)) in Q0.16, with the zero-variance rule.
    function automatic longint unsigned gauss_term(longint unsigned sq, longint unsigned variance);
        longint unsigned q;
        longint unsigned a;
        longint unsigned b;
        longint unsigned v;
        if (variance == 0)
            return (sq == 0) ? 64'd65536 : 64'd0;
        q = sq / (2 * variance);
        if (q >= (64'd16 << 16))
            return 0;
        a = exp_tbl[q >> FRAC];
        b = exp_tbl[(q >> FRAC) + 1];
        v = a - (((a - b) * (q & ((64'd1 << FRAC) - 1))) >> FRAC);
        return (v + (64'd1 << 14)) >> 15;
    endfunction

    function automatic shrink_res_t shrink_coef(logic signed [COEF_W-1:0] y);
        shrink_res_t     res;
        longint          dev;
        longint unsigned ad;
        longint unsigned sq;
        longint unsigned e1;
        longint unsigned e2;
        longint unsigned w;
        longint unsigned s;
        longint unsigned m;
        longint unsigned ay;
        longint unsigned mag;
        res.thru = 1'b0;
        res.coef = '0;
        if (sig_q == 0 && noi_q == 0)
            return res;
        dev = longint'(y) - mu_q;
        ad = (dev < 0) ? longint'(-dev) : longint'(dev);
        sq = ad * ad;
        e1 = gauss_term(sq, noi_q);
        e2 = gauss_term(sq, sig_q + noi_q);
        if (e1 + e2 == 0)
        begin
            res.coef = y;
            res.thru = 1'b1;
            return res;
        end
        w = (e2 << 31) / (e1 + e2);
        s = (sig_q << 31) / (sig_q + noi_q);
        m = (s * w) >> 31;
        ay = (y < 0) ? longint'(-longint'(y)) : longint'(y);
        mag = (ay * m + (64'd1 << 30)) >> 31;
        // The gain never exceeds one, so the magnitude stays in range.
        res.coef = (y < 0) ? -mag[31:0] : mag[31:0];
        return res;
    endfunction

    // Sender: keeps an item on the bus until accepted, predicts it on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            coef_in <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                shrink_expected.insert(shrink_expected.size(), shrink_coef(coef_in));
                void'(coef_pending.pop_front());
            end
            // The accepted item has left the queue, so the next one is at the front.
            if (in_valid && !in_ready)
                in_valid <= 1'b1;
            else if (coef_pending.size() > 0 && !hold_off
                     && $urandom_range(99) >= snd_idle)
            begin
                in_valid <= 1'b1;
                coef_in <= coef_pending[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: checks each result item against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (shrink_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result coef_out=%0d passed_through=%0b",
                                 coef_out, passed_through);
                end
                else
                begin
                    if (coef_out !== shrink_expected[0].coef
                        || passed_through !== shrink_expected[0].thru)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                     shrink_expected[0].coef, shrink_expected[0].thru,
                                     coef_out, passed_through);
                    end
                    void'(shrink_expected.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bayesian_wavelet_shrink_tb: errors");
            $finish;
        end
    end

    // Waits until the pipeline holds nothing, then lets it settle.
    task automatic drain();
        while (coef_pending.size() != 0 || in_valid || shrink_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers, one after another, while idle.
    task automatic set_regs(logic [31:0] mu, logic [31:0] sp, logic [31:0] np);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MEAN_OFFSET;
        cfg_data <= mu;
        @(posedge clk);
        cfg_index <= CFG_SIGNAL_POWER;
        cfg_data <= sp;
        @(posedge clk);
        cfg_index <= CFG_NOISE_POWER;
        cfg_data <= np;
        @(posedge clk);
        cfg_write <= 1'b0;
        mu_q = longint'(signed'(mu));
        sig_q = sp;
        noi_q = np;
    endtask

    // Idling follows the share of items queued so far.
    task automatic queue_coef(logic [31:0] y);
        if (items_queued < 180)
        begin
            snd_idle = 9;
            rcv_idle = 88;
        end
        else if (items_queued < 360)
        begin
            snd_idle = 88;
            rcv_idle = 9;
        end
        else
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        coef_pending.insert(coef_pending.size(), y);
        items_queued++;
    endtask

    // Coefficients mostly near the mean so the exponentials stay in the table.
    function automatic logic [31:0] random_coef();
        logic [31:0] span;
        case ($urandom_range(3))
            0: return $urandom;
            default:
            begin
                span = $urandom >> $urandom_range(31);
                return mu_q[31:0] + ($urandom_range(1) ? span : -span);
            end
        endcase
    endfunction

    function automatic logic [31:0] random_power();
        if ($urandom_range(9) == 0)
            return 32'd0;
        return $urandom >> $urandom_range(31);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_MEAN_OFFSET;
        cfg_data = '0;
        hold_off = 1'b0;
        mismatches = 0;
        cycles = 0;
        items_queued = 0;
        snd_idle = 9;
        rcv_idle = 88;
        mu_q = 0;
        sig_q = 0;
        noi_q = 0;
        build_exp_table();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Both variances zero after reset: every output is zero.
        queue_coef(32'h7fff_ffff);
        queue_coef(32'h8000_0000);
        queue_coef(32'h0);
        drain();

        // Zero noise variance: the deviation of zero gives the 0/0 term.
        set_regs(32'h0001_0000, 32'h0004_0000, 32'h0);
        queue_coef(32'h0001_0000);
        queue_coef(32'h0001_8000);
        queue_coef(32'hffff_0000);
        drain();

        // Zero signal variance: the gain is zero.
        set_regs(32'h0, 32'h0, 32'h0002_0000);
        queue_coef(32'h0003_0000);
        queue_coef(32'hfffd_0000);
        drain();

        // Tiny variances: the far coefficients make the denominator vanish, the near ones do not.
        set_regs(32'h0, 32'h1, 32'h1);
        queue_coef(32'h7fff_ffff);
        queue_coef(32'h8000_0000);
        queue_coef(32'h0);
        queue_coef(32'h1);
        drain();

        // Extreme mean offsets, full-scale signal variance, full-scale and then unit noise variance.
        set_regs(32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
        queue_coef(32'h7fff_ffff);
        queue_coef(32'h8000_0000);
        queue_coef(32'hffff_ffff);
        drain();
        set_regs(32'h7fff_ffff, 32'hffff_ffff, 32'h1);
        queue_coef(32'h8000_0000);
        queue_coef(32'h7fff_ffff);
        queue_coef(32'h7fff_0000);
        queue_coef(32'h5555_aaaa);
        drain();

        // Random phases, each under a fresh register setting.
        for (int ph = 0; ph < 10; ph++)
        begin
            set_regs($urandom, random_power(), random_power());
            for (int i = 0; i < 50; i++)
                queue_coef(random_coef());
            if (ph == 4)
            begin
                // Hold the sender until every queued prediction has come back.
                while (coef_pending.size() > 25)
                    @(posedge clk);
                hold_off = 1'b1;
                while (in_valid || shrink_expected.size() != 0)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("bayesian_wavelet_shrink_tb: clean");
        else
            $display("bayesian_wavelet_shrink_tb: errors");
        $finish;
    end

endmodule
